>>> design/crs_pkg.sv
// Package for the clip rectangle stack: request/response structs, opcodes,
// error codes and coordinate constants. No dependencies.
`default_nettype none

package crs_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int LIMIT_WIDTH = 15;
    localparam int OP_WIDTH    = 3;
    localparam int ERR_WIDTH   = 2;
    localparam int ENTRY_WIDTH = 4 * COORD_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [LIMIT_WIDTH-1:0] limit_t;
    typedef logic [OP_WIDTH-1:0] opcode_t;
    typedef logic [ERR_WIDTH-1:0] err_t;

    localparam opcode_t OP_PUSH   = 3'd0;
    localparam opcode_t OP_POP    = 3'd1;
    localparam opcode_t OP_REOPEN = 3'd2;
    localparam opcode_t OP_LEFT   = 3'd3;
    localparam opcode_t OP_TOP    = 3'd4;
    localparam opcode_t OP_RIGHT  = 3'd5;
    localparam opcode_t OP_BOTTOM = 3'd6;
    localparam opcode_t OP_RECT   = 3'd7;

    localparam err_t ERR_OK         = 2'd0;
    localparam err_t ERR_OVERFLOW   = 2'd1;
    localparam err_t ERR_UNDERFLOW  = 2'd2;
    localparam err_t ERR_EMPTY_EDIT = 2'd3;

    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    localparam limit_t LIMIT_RESET = 15'h7FFF;

    // Config register index (byte address 4*i, index taken from paddr[2])
    localparam logic REG_CLIP_LIMIT = 1'b0;

    // Bound lanes inside one stack entry
    localparam int LANE_LEFT   = 0;
    localparam int LANE_TOP    = 1;
    localparam int LANE_RIGHT  = 2;
    localparam int LANE_BOTTOM = 3;

    typedef struct packed {
        opcode_t opcode;
        coord_t  distance;
        coord_t  origin_x;
        coord_t  origin_y;
        coord_t  extent_x;
        coord_t  extent_y;
    } req_t;

    typedef struct packed {
        coord_t     bound_left;
        coord_t     bound_top;
        coord_t     bound_right;
        coord_t     bound_bottom;
        logic [3:0] plane_enables;
        logic       stack_active;
        err_t       error_code;
    } rsp_t;

    typedef struct packed {
        logic load_req;
        logic exec_op;
        logic scan_read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> design/clip_rectangle_stack.sv
// Clip rectangle stack with running intersection of all levels.
// A request is registered, applied to the level memory, then all levels are scanned and the result
// is loaded into the output register. No new request is taken (req_stall high) until that load;
// the scan reads one level per cycle from the level memory.
// Reset: level count 0, clip_limit 32767, no response pending; level memory not cleared.
// Depends on crs_pkg, crs_ctrl, crs_datapath.
`default_nettype none

module clip_rectangle_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire crs_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output crs_pkg::rsp_t      rsp,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    crs_pkg::limit_t clip_limit_reg;
    crs_pkg::cmd_t   cmd;
    crs_pkg::sts_t   sts;
    logic            limit_sel;

    assign pready    = 1'b1;
    assign limit_sel = (paddr[2] == crs_pkg::REG_CLIP_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_limit_reg <= crs_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && limit_sel)
        begin
            clip_limit_reg <= pwdata[crs_pkg::LIMIT_WIDTH-1:0];
        end
    end

    assign prdata = limit_sel ? {{(32-crs_pkg::LIMIT_WIDTH){1'b0}}, clip_limit_reg} : '0;

    crs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    crs_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .clip_limit (clip_limit_reg),
        .cmd        (cmd),
        .sts        (sts),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

>>> design/crs_ctrl.sv
// Sequencer for the clip rectangle stack: accepts a request, runs the
// update, the level scan and the output load. Uses crs_pkg.
`default_nettype none

module crs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire crs_pkg::sts_t sts,
    output crs_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec_op = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.empty)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_read = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> design/crs_datapath.sv
// Datapath for the clip rectangle stack: level memory, level count, bound
// update, min/max scan and the output register. Uses crs_pkg.
`default_nettype none

module crs_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire crs_pkg::req_t   req,
    input  wire crs_pkg::limit_t clip_limit,
    input  wire crs_pkg::cmd_t   cmd,
    output crs_pkg::sts_t        sts,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output crs_pkg::rsp_t        rsp
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int W  = crs_pkg::COORD_WIDTH;

    logic [crs_pkg::ENTRY_WIDTH-1:0] mem [STACK_DEPTH];

    crs_pkg::req_t   req_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    crs_pkg::err_t   err_reg;
    crs_pkg::err_t   err_next;
    logic [CW-1:0]   scan_reg;
    logic            rd_valid_reg;
    logic [crs_pkg::ENTRY_WIDTH-1:0] rd_data_reg;
    crs_pkg::coord_t acc_reg [4];
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    crs_pkg::rsp_t   rsp_reg;
    crs_pkg::rsp_t   rsp_next;

    logic [3:0]      wr_mask;
    logic [AW-1:0]   wr_addr;
    crs_pkg::coord_t wr_val [4];
    logic [CW-1:0]   count_m1;
    logic            is_empty;
    logic            is_full;
    crs_pkg::coord_t open_lo;
    crs_pkg::coord_t open_hi;
    logic signed [W:0] sum_x;
    logic signed [W:0] sum_y;
    crs_pkg::coord_t sat_x;
    crs_pkg::coord_t sat_y;
    logic signed [W:0] lim_ext;

    assign count_m1 = count_reg - 1'b1;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(STACK_DEPTH));

    assign open_hi = crs_pkg::coord_t'({1'b0, clip_limit});
    assign open_lo = -open_hi;

    assign sum_x = {req_reg.origin_x[W-1], req_reg.origin_x}
                 + {req_reg.extent_x[W-1], req_reg.extent_x};
    assign sum_y = {req_reg.origin_y[W-1], req_reg.origin_y}
                 + {req_reg.extent_y[W-1], req_reg.extent_y};
    assign sat_x = (sum_x[W] != sum_x[W-1])
                 ? (sum_x[W] ? crs_pkg::COORD_MIN : crs_pkg::COORD_MAX) : sum_x[W-1:0];
    assign sat_y = (sum_y[W] != sum_y[W-1])
                 ? (sum_y[W] ? crs_pkg::COORD_MIN : crs_pkg::COORD_MAX) : sum_y[W-1:0];

    // update of the level count, error code and top entry
    always_comb
    begin
        wr_mask    = 4'b0000;
        wr_addr    = count_m1[AW-1:0];
        count_next = count_reg;
        err_next   = err_reg;
        for (int k = 0; k < 4; k++)
        begin
            wr_val[k] = req_reg.distance;
        end
        if (cmd.exec_op)
        begin
            err_next = crs_pkg::ERR_OK;
            unique case (req_reg.opcode)
                crs_pkg::OP_PUSH:
                begin
                    if (is_full)
                    begin
                        err_next = crs_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        wr_mask    = 4'b1111;
                        wr_addr    = count_reg[AW-1:0];
                        count_next = count_reg + 1'b1;
                        wr_val[crs_pkg::LANE_LEFT]   = open_lo;
                        wr_val[crs_pkg::LANE_TOP]    = open_lo;
                        wr_val[crs_pkg::LANE_RIGHT]  = open_hi;
                        wr_val[crs_pkg::LANE_BOTTOM] = open_hi;
                    end
                end
                crs_pkg::OP_POP:
                begin
                    if (is_empty)
                    begin
                        err_next = crs_pkg::ERR_UNDERFLOW;
                    end
                    else
                    begin
                        count_next = count_m1;
                    end
                end
                default:
                begin
                    if (is_empty)
                    begin
                        err_next = crs_pkg::ERR_EMPTY_EDIT;
                    end
                    else
                    begin
                        case (req_reg.opcode)
                            crs_pkg::OP_REOPEN:
                            begin
                                wr_mask = 4'b1111;
                                wr_val[crs_pkg::LANE_LEFT]   = open_lo;
                                wr_val[crs_pkg::LANE_TOP]    = open_lo;
                                wr_val[crs_pkg::LANE_RIGHT]  = open_hi;
                                wr_val[crs_pkg::LANE_BOTTOM] = open_hi;
                            end
                            crs_pkg::OP_LEFT:   wr_mask = 4'b0001;
                            crs_pkg::OP_TOP:    wr_mask = 4'b0010;
                            crs_pkg::OP_RIGHT:  wr_mask = 4'b0100;
                            crs_pkg::OP_BOTTOM: wr_mask = 4'b1000;
                            default:
                            begin
                                wr_mask = 4'b1111;
                                wr_val[crs_pkg::LANE_LEFT]   = req_reg.origin_x;
                                wr_val[crs_pkg::LANE_TOP]    = req_reg.origin_y;
                                wr_val[crs_pkg::LANE_RIGHT]  = sat_x;
                                wr_val[crs_pkg::LANE_BOTTOM] = sat_y;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (wr_mask[k])
            begin
                mem[wr_addr][k*W +: W] <= wr_val[k];
            end
        end
        if (cmd.scan_read)
        begin
            rd_data_reg <= mem[scan_reg[AW-1:0]];
        end
    end

    assign sts.empty     = is_empty;
    assign sts.scan_last = (scan_reg == count_m1);
    assign sts.out_free  = !rsp_valid_reg || !rsp_stall;

    // output assembly
    assign lim_ext = {2'b00, clip_limit};

    always_comb
    begin
        rsp_next = '0;
        rsp_next.error_code = err_reg;
        if (!is_empty)
        begin
            rsp_next.stack_active = 1'b1;
            rsp_next.bound_left   = acc_reg[crs_pkg::LANE_LEFT];
            rsp_next.bound_top    = acc_reg[crs_pkg::LANE_TOP];
            rsp_next.bound_right  = acc_reg[crs_pkg::LANE_RIGHT];
            rsp_next.bound_bottom = acc_reg[crs_pkg::LANE_BOTTOM];
            rsp_next.plane_enables[0] =
                $signed({acc_reg[crs_pkg::LANE_LEFT][W-1], acc_reg[crs_pkg::LANE_LEFT]})
                > -lim_ext;
            rsp_next.plane_enables[1] =
                $signed({acc_reg[crs_pkg::LANE_TOP][W-1], acc_reg[crs_pkg::LANE_TOP]})
                > -lim_ext;
            rsp_next.plane_enables[2] =
                $signed({acc_reg[crs_pkg::LANE_RIGHT][W-1], acc_reg[crs_pkg::LANE_RIGHT]})
                < lim_ext;
            rsp_next.plane_enables[3] =
                $signed({acc_reg[crs_pkg::LANE_BOTTOM][W-1], acc_reg[crs_pkg::LANE_BOTTOM]})
                < lim_ext;
        end
    end

    assign rsp_valid_next = cmd.out_load ? 1'b1 : (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_valid_reg  <= cmd.scan_read;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.exec_op)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_read)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.exec_op)
        begin
            acc_reg[crs_pkg::LANE_LEFT]   <= crs_pkg::COORD_MIN;
            acc_reg[crs_pkg::LANE_TOP]    <= crs_pkg::COORD_MIN;
            acc_reg[crs_pkg::LANE_RIGHT]  <= crs_pkg::COORD_MAX;
            acc_reg[crs_pkg::LANE_BOTTOM] <= crs_pkg::COORD_MAX;
        end
        else if (rd_valid_reg)
        begin
            for (int k = 0; k < 2; k++)
            begin
                if ($signed(rd_data_reg[k*W +: W]) > acc_reg[k])
                begin
                    acc_reg[k] <= rd_data_reg[k*W +: W];
                end
            end
            for (int k = 2; k < 4; k++)
            begin
                if ($signed(rd_data_reg[k*W +: W]) < acc_reg[k])
                begin
                    acc_reg[k] <= rd_data_reg[k*W +: W];
                end
            end
        end
        if (cmd.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> bench/tb_clip_rectangle_stack.sv
// Testbench for clip_rectangle_stack: predicts each response from a local copy of the
// level stack and clip limit and checks it field by field under random request gaps and stalls.
// Depends on crs_pkg and the clip_rectangle_stack RTL.
`timescale 1ns / 100ps

module tb_clip_rectangle_stack;

    localparam int TB_DEPTH       = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 560;
    localparam int TAIL_CYCLES    = TB_DEPTH + 8;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    crs_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    crs_pkg::rsp_t  rsp;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    // predictor state
    crs_pkg::coord_t level_store [TB_DEPTH][4];
    int              level_depth = 0;
    crs_pkg::limit_t clip_limit_now = crs_pkg::LIMIT_RESET;

    crs_pkg::rsp_t pending_bounds [$];
    int     error_count = 0;
    int     next_gap = 1;
    int     rsp_hold = 0;
    int     quiet_cycles = 0;
    bit     steady_flow = 1'b0;

    clip_rectangle_stack #(
        .STACK_DEPTH(TB_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic crs_pkg::coord_t clamp_coord(int v);
        if (v > crs_pkg::COORD_MAX)
            return crs_pkg::COORD_MAX;
        if (v < crs_pkg::COORD_MIN)
            return crs_pkg::COORD_MIN;
        return crs_pkg::coord_t'(v);
    endfunction

    function automatic void open_level(int lv);
        int lim;
        lim = clip_limit_now;
        level_store[lv][crs_pkg::LANE_LEFT]   = clamp_coord(-lim);
        level_store[lv][crs_pkg::LANE_TOP]    = clamp_coord(-lim);
        level_store[lv][crs_pkg::LANE_RIGHT]  = clamp_coord(lim);
        level_store[lv][crs_pkg::LANE_BOTTOM] = clamp_coord(lim);
    endfunction

    function automatic crs_pkg::rsp_t predict_intersection(crs_pkg::req_t r);
        crs_pkg::rsp_t res;
        int   b [4];
        int   lim;
        int   top;
        res = '0;
        res.error_code = crs_pkg::ERR_OK;
        lim = clip_limit_now;
        case (r.opcode)
            crs_pkg::OP_PUSH:
            begin
                if (level_depth >= TB_DEPTH)
                    res.error_code = crs_pkg::ERR_OVERFLOW;
                else
                begin
                    open_level(level_depth);
                    level_depth++;
                end
            end
            crs_pkg::OP_POP:
            begin
                if (level_depth == 0)
                    res.error_code = crs_pkg::ERR_UNDERFLOW;
                else
                    level_depth--;
            end
            default:
            begin
                if (level_depth == 0)
                    res.error_code = crs_pkg::ERR_EMPTY_EDIT;
                else
                begin
                    top = level_depth - 1;
                    case (r.opcode)
                        crs_pkg::OP_REOPEN: open_level(top);
                        crs_pkg::OP_LEFT:
                            level_store[top][crs_pkg::LANE_LEFT]   = r.distance;
                        crs_pkg::OP_TOP:
                            level_store[top][crs_pkg::LANE_TOP]    = r.distance;
                        crs_pkg::OP_RIGHT:
                            level_store[top][crs_pkg::LANE_RIGHT]  = r.distance;
                        crs_pkg::OP_BOTTOM:
                            level_store[top][crs_pkg::LANE_BOTTOM] = r.distance;
                        default:
                        begin
                            level_store[top][crs_pkg::LANE_LEFT]   = r.origin_x;
                            level_store[top][crs_pkg::LANE_TOP]    = r.origin_y;
                            level_store[top][crs_pkg::LANE_RIGHT]  = clamp_coord(
                                int'($signed(r.origin_x)) + int'($signed(r.extent_x)));
                            level_store[top][crs_pkg::LANE_BOTTOM] = clamp_coord(
                                int'($signed(r.origin_y)) + int'($signed(r.extent_y)));
                        end
                    endcase
                end
            end
        endcase
        if (level_depth != 0)
        begin
            for (int lane = 0; lane < 4; lane++)
                b[lane] = level_store[0][lane];
            for (int i = 1; i < level_depth; i++)
            begin
                if (level_store[i][crs_pkg::LANE_LEFT] > b[crs_pkg::LANE_LEFT])
                    b[crs_pkg::LANE_LEFT] = level_store[i][crs_pkg::LANE_LEFT];
                if (level_store[i][crs_pkg::LANE_TOP] > b[crs_pkg::LANE_TOP])
                    b[crs_pkg::LANE_TOP] = level_store[i][crs_pkg::LANE_TOP];
                if (level_store[i][crs_pkg::LANE_RIGHT] < b[crs_pkg::LANE_RIGHT])
                    b[crs_pkg::LANE_RIGHT] = level_store[i][crs_pkg::LANE_RIGHT];
                if (level_store[i][crs_pkg::LANE_BOTTOM] < b[crs_pkg::LANE_BOTTOM])
                    b[crs_pkg::LANE_BOTTOM] = level_store[i][crs_pkg::LANE_BOTTOM];
            end
            res.bound_left       = crs_pkg::coord_t'(b[crs_pkg::LANE_LEFT]);
            res.bound_top        = crs_pkg::coord_t'(b[crs_pkg::LANE_TOP]);
            res.bound_right      = crs_pkg::coord_t'(b[crs_pkg::LANE_RIGHT]);
            res.bound_bottom     = crs_pkg::coord_t'(b[crs_pkg::LANE_BOTTOM]);
            res.plane_enables[0] = b[crs_pkg::LANE_LEFT] > -lim;
            res.plane_enables[1] = b[crs_pkg::LANE_TOP] > -lim;
            res.plane_enables[2] = b[crs_pkg::LANE_RIGHT] < lim;
            res.plane_enables[3] = b[crs_pkg::LANE_BOTTOM] < lim;
            res.stack_active     = 1'b1;
        end
        return res;
    endfunction

    function automatic int draw_wait();
        return steady_flow ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic crs_pkg::coord_t pick_coord();
        int lim;
        lim = clip_limit_now;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return crs_pkg::COORD_MIN;
                    1: return crs_pkg::COORD_MAX;
                    2: return crs_pkg::coord_t'(0);
                    default: return crs_pkg::coord_t'(-1);
                endcase
            end
            1: return clamp_coord(-lim + $urandom_range(0, 2) - 1);
            2: return clamp_coord(lim + $urandom_range(0, 2) - 1);
            default: return crs_pkg::coord_t'($urandom());
        endcase
    endfunction

    function automatic crs_pkg::req_t random_request(crs_pkg::opcode_t op);
        crs_pkg::req_t r;
        r.opcode   = op;
        r.distance = pick_coord();
        r.origin_x = pick_coord();
        r.origin_y = pick_coord();
        r.extent_x = pick_coord();
        r.extent_y = pick_coord();
        return r;
    endfunction

    function automatic crs_pkg::opcode_t pick_op(int push_weight, int pop_weight);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_weight)
            return crs_pkg::OP_PUSH;
        if (roll < push_weight + pop_weight)
            return crs_pkg::OP_POP;
        return crs_pkg::opcode_t'($urandom_range(crs_pkg::OP_REOPEN, crs_pkg::OP_RECT));
    endfunction

    function automatic crs_pkg::limit_t pick_limit();
        case ($urandom_range(0, 4))
            0: return crs_pkg::limit_t'(0);
            1: return crs_pkg::LIMIT_RESET;
            2: return crs_pkg::limit_t'($urandom_range(1, 64));
            default: return crs_pkg::limit_t'($urandom());
        endcase
    endfunction

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                expected, actual);
            error_count++;
        end
    endfunction

    task automatic send_request(crs_pkg::req_t r);
        repeat (next_gap) @(posedge clk);
        req       <= r;
        req_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        pending_bounds.push_back(predict_intersection(r));
        next_gap = draw_wait();
        if (next_gap != 0)
            req_valid <= 1'b0;
    endtask

    task automatic send_op(crs_pkg::opcode_t op, crs_pkg::coord_t value);
        crs_pkg::req_t r;
        r = random_request(op);
        r.distance = value;
        send_request(r);
    endtask

    task automatic send_rect(crs_pkg::coord_t ox, crs_pkg::coord_t oy,
                             crs_pkg::coord_t ex, crs_pkg::coord_t ey);
        crs_pkg::req_t r;
        r = random_request(crs_pkg::OP_RECT);
        r.origin_x = ox;
        r.origin_y = oy;
        r.extent_x = ex;
        r.extent_y = ey;
        send_request(r);
    endtask

    task automatic wait_idle();
        if (next_gap == 0)
        begin
            req_valid <= 1'b0;
            next_gap = 1;
        end
        while (pending_bounds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_clip_limit(crs_pkg::limit_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {crs_pkg::REG_CLIP_LIMIT, 2'b00};
        pwdata  <= {{(32 - crs_pkg::LIMIT_WIDTH){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        clip_limit_now = value;
    endtask

    task automatic test_empty_stack();
        send_op(crs_pkg::OP_POP, crs_pkg::coord_t'(0));
        for (int op = crs_pkg::OP_REOPEN; op <= crs_pkg::OP_RECT; op++)
            send_op(crs_pkg::opcode_t'(op), pick_coord());
    endtask

    task automatic test_single_level();
        send_op(crs_pkg::OP_PUSH, crs_pkg::COORD_MAX);
        send_op(crs_pkg::OP_LEFT, crs_pkg::COORD_MIN);
        send_op(crs_pkg::OP_TOP, crs_pkg::COORD_MAX);
        send_op(crs_pkg::OP_RIGHT, crs_pkg::COORD_MIN);
        send_op(crs_pkg::OP_BOTTOM, crs_pkg::COORD_MAX);
        // saturating rectangle sums, both directions
        send_rect(crs_pkg::COORD_MAX, crs_pkg::COORD_MIN,
                  crs_pkg::COORD_MAX, crs_pkg::COORD_MIN);
        send_rect(crs_pkg::COORD_MIN, crs_pkg::COORD_MAX,
                  crs_pkg::coord_t'(-1), crs_pkg::coord_t'(1));
        send_rect(crs_pkg::coord_t'(-100), crs_pkg::coord_t'(50),
                  crs_pkg::coord_t'(200), crs_pkg::coord_t'(-30));
        send_op(crs_pkg::OP_REOPEN, crs_pkg::coord_t'(0));
        send_op(crs_pkg::OP_PUSH, crs_pkg::coord_t'(0));
        send_op(crs_pkg::OP_LEFT, crs_pkg::coord_t'(16));
        send_op(crs_pkg::OP_BOTTOM, crs_pkg::coord_t'(-16));
        send_op(crs_pkg::OP_POP, crs_pkg::coord_t'(0));
        send_op(crs_pkg::OP_POP, crs_pkg::coord_t'(0));
    endtask

    task automatic test_full_stack();
        for (int i = 0; i <= TB_DEPTH; i++)
        begin
            send_request(random_request(crs_pkg::OP_PUSH));
            if ($urandom_range(0, 1) == 1)
                send_request(random_request(crs_pkg::opcode_t'(
                    $urandom_range(crs_pkg::OP_REOPEN, crs_pkg::OP_RECT))));
        end
        for (int i = 0; i <= TB_DEPTH; i++)
            send_request(random_request(crs_pkg::OP_POP));
    endtask

    task automatic test_limit_changes();
        crs_pkg::limit_t settings [5];
        int     lim;
        settings[0] = crs_pkg::limit_t'(0);
        settings[1] = crs_pkg::limit_t'(1);
        settings[2] = crs_pkg::limit_t'(16384);
        settings[3] = crs_pkg::limit_t'($urandom());
        settings[4] = crs_pkg::LIMIT_RESET;
        foreach (settings[k])
        begin
            wait_idle();
            write_clip_limit(settings[k]);
            lim = settings[k];
            // earlier levels keep the limit they were opened with
            send_op(crs_pkg::OP_PUSH, crs_pkg::coord_t'(0));
            send_op(crs_pkg::OP_LEFT, clamp_coord(-lim));
            send_op(crs_pkg::OP_TOP, clamp_coord(-lim + 1));
            send_op(crs_pkg::OP_RIGHT, clamp_coord(lim));
            send_op(crs_pkg::OP_BOTTOM, clamp_coord(lim - 1));
            send_op(crs_pkg::OP_PUSH, crs_pkg::coord_t'(0));
        end
    endtask

    task automatic test_random_mix();
        int sent;
        int seg_len;
        int push_weight;
        int pop_weight;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady_flow = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_clip_limit(pick_limit());
            end
            case ($urandom_range(0, 2))
                0:
                begin
                    push_weight = 40;
                    pop_weight  = 10;
                end
                1:
                begin
                    push_weight = 10;
                    pop_weight  = 40;
                end
                default:
                begin
                    push_weight = 25;
                    pop_weight  = 25;
                end
            endcase
            seg_len = $urandom_range(20, 60);
            for (int i = 0; i < seg_len; i++)
                send_request(random_request(pick_op(push_weight, pop_weight)));
            sent += seg_len;
        end
        steady_flow = 1'b0;
    endtask

    // response checker and receiver stall
    always @(posedge clk)
    begin
        crs_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_bounds.size() == 0)
            begin
                $display("%0t: response with no request outstanding, actual %h", $time, rsp);
                error_count++;
            end
            else
            begin
                want = pending_bounds.pop_front();
                check_field("bound_left", want.bound_left, rsp.bound_left);
                check_field("bound_top", want.bound_top, rsp.bound_top);
                check_field("bound_right", want.bound_right, rsp.bound_right);
                check_field("bound_bottom", want.bound_bottom, rsp.bound_bottom);
                check_field("plane_enables", want.plane_enables, rsp.plane_enables);
                check_field("stack_active", want.stack_active, rsp.stack_active);
                check_field("error_code", want.error_code, rsp.error_code);
            end
            rsp_hold = draw_wait();
        end
        else if (rsp_hold > 0)
            rsp_hold--;
        rsp_stall <= rst_n && (rsp_hold != 0);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack();
        test_single_level();
        test_full_stack();
        test_limit_changes();
        test_random_mix();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
